// File: rtl/deq_pkg.sv
// Package with the shared constants, types and ring helpers of the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // Number of slots in the ring.
    localparam int DEPTH = 16;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 64;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [OP_W-1:0] OP_REVERSE    = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [WORD_W-1:0]   word_t;

    // One 24-character entry.
    typedef struct packed {
        word_t high;
        word_t mid;
        word_t low;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Registered outcome of one transaction, passed from the control to the output stage.
    typedef struct packed {
        status_t status;
        cnt_t    count;
        logic    empty;
        logic    rev;
        logic    hit_first;
        logic    hit_last;
    } ctrl_result_t;

    function automatic ptr_t ptr_next(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    function automatic ptr_t ptr_prev(input ptr_t p);
        ptr_t r;
        if (p == '0)
            r = PTR_W'(DEPTH - 1);
        else
            r = p - 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/deq_if.sv
// Valid/ready channel interfaces for the request and response of the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

interface deq_req_if
    import deq_pkg::*;
;
    logic  valid;
    logic  ready;
    op_t   op;
    word_t text_word_low;
    word_t text_word_mid;
    word_t text_word_high;

    modport source (output valid, output op, output text_word_low, output text_word_mid,
                    output text_word_high, input ready);
    modport sink   (input valid, input op, input text_word_low, input text_word_mid,
                    input text_word_high, output ready);
endinterface

interface deq_rsp_if
    import deq_pkg::*;
;
    logic    valid;
    logic    ready;
    status_t status;
    cnt_t    count;
    word_t   front_word_low;
    word_t   front_word_mid;
    word_t   front_word_high;
    word_t   back_word_low;
    word_t   back_word_mid;
    word_t   back_word_high;

    modport source (output valid, output status, output count,
                    output front_word_low, output front_word_mid, output front_word_high,
                    output back_word_low, output back_word_mid, output back_word_high,
                    input ready);
    modport sink   (input valid, input status, input count,
                    input front_word_low, input front_word_mid, input front_word_high,
                    input back_word_low, input back_word_mid, input back_word_high,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/deq_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]                        rd_data_a,
    output logic      [WIDTH-1:0]                        rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Reads return the old contents when the same address is written in that cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// File: rtl/deq_ctrl.sv
// Pointer, count and direction control of the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         fire,
    input  wire op_t          op,
    output logic              wr_en,
    output ptr_t              wr_addr,
    output ptr_t              rd_addr_first,
    output ptr_t              rd_addr_last,
    output ctrl_result_t      res_reg
);

    ptr_t    head_reg, head_next;
    ptr_t    tail_reg, tail_next;
    cnt_t    count_reg, count_next;
    logic    rev_reg, rev_next;
    status_t status;
    logic    is_push, is_pop, to_first;
    logic    full, empty;
    ctrl_result_t res_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        status     = ST_DONE;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;

        is_push  = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
        is_pop   = (op == OP_POP_FRONT) || (op == OP_POP_BACK);
        full     = (count_reg == CNT_W'(DEPTH));
        empty    = (count_reg == '0);
        // In reversed order the logical front is the physical last slot.
        to_first = ((op == OP_PUSH_FRONT) || (op == OP_POP_FRONT)) != rev_reg;

        if (is_push)
        begin
            if (full)
            begin
                status = ST_FULL;
            end
            else if (to_first)
            begin
                head_next  = ptr_prev(head_reg);
                wr_en      = fire;
                wr_addr    = head_next;
                count_next = count_reg + 1'b1;
            end
            else
            begin
                wr_en      = fire;
                wr_addr    = tail_reg;
                tail_next  = ptr_next(tail_reg);
                count_next = count_reg + 1'b1;
            end
        end
        else if (is_pop)
        begin
            if (empty)
            begin
                status = ST_EMPTY;
            end
            else if (to_first)
            begin
                head_next  = ptr_next(head_reg);
                count_next = count_reg - 1'b1;
            end
            else
            begin
                tail_next  = ptr_prev(tail_reg);
                count_next = count_reg - 1'b1;
            end
        end
        else if (op == OP_REVERSE)
        begin
            rev_next = ~rev_reg;
        end

        // The result shows the ends of the queue as they stand after this transaction.
        rd_addr_first = head_next;
        rd_addr_last  = ptr_prev(tail_next);

        res_next.status    = status;
        res_next.count     = count_next;
        res_next.empty     = (count_next == '0);
        res_next.rev       = rev_next;
        res_next.hit_first = wr_en && (wr_addr == rd_addr_first);
        res_next.hit_last  = wr_en && (wr_addr == rd_addr_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
            res_reg   <= '0;
        end
        else if (fire)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            res_reg   <= res_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/double_ended_queue.sv
// Top level of the double-ended queue of 24-character entries.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a double-ended queue of up to DEPTH entries of 24 characters, each
// carried as three 64-bit words, in a ring held in a two-read-port RAM.
// The req channel carries one operation per transaction: query, push front, push back,
// pop front, pop back or reverse, plus the entry to push. Reverse only toggles a
// direction flag; no data moves.
// The rsp channel returns exactly one transaction per request: the status (done, pop
// refused because empty, push refused because full), the entry count after the
// operation and the front and back entries, all zero when the queue is empty.
// The response is valid in the cycle after the request is accepted. Throughput is one
// operation per cycle while the receiver takes each response; the pointer update, the RAM
// write and the two RAM reads of one operation all take place at the same clock edge.
// A slot that is written in the same cycle as it is read is forwarded from a copy of
// the pushed entry, so a push is seen at once in its response.
// When the receiver stalls, the response is held and req.ready drops until it is taken;
// a new request is accepted in the same cycle as the held response leaves.
// Reset empties the queue and restores normal order. The RAM is not cleared: only slots
// that have been written are ever shown.
module double_ended_queue
    import deq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);

    logic         fire;
    logic         out_valid_reg;
    logic         wr_en;
    ptr_t         wr_addr;
    ptr_t         rd_addr_first;
    ptr_t         rd_addr_last;
    ctrl_result_t res_reg;
    entry_t       push_entry;
    entry_t       wdata_reg;
    entry_t       rd_first;
    entry_t       rd_last;
    entry_t       first_entry;
    entry_t       last_entry;
    entry_t       front_entry;
    entry_t       back_entry;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;

    assign push_entry.low  = req.text_word_low;
    assign push_entry.mid  = req.text_word_mid;
    assign push_entry.high = req.text_word_high;

    deq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .op            (req.op),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .rd_addr_first (rd_addr_first),
        .rd_addr_last  (rd_addr_last),
        .res_reg       (res_reg)
    );

    deq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (push_entry),
        .rd_en     (fire),
        .rd_addr_a (rd_addr_first),
        .rd_addr_b (rd_addr_last),
        .rd_data_a (rd_first),
        .rd_data_b (rd_last)
    );

    // Copy of the pushed entry for the forwarding path.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            wdata_reg <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Pick physical ends, blank them when empty, then map them to logical ends.
    always_comb
    begin
        first_entry = res_reg.hit_first ? wdata_reg : rd_first;
        last_entry  = res_reg.hit_last  ? wdata_reg : rd_last;
        if (res_reg.empty)
        begin
            first_entry = '0;
            last_entry  = '0;
        end
        if (res_reg.rev)
        begin
            front_entry = last_entry;
            back_entry  = first_entry;
        end
        else
        begin
            front_entry = first_entry;
            back_entry  = last_entry;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = res_reg.status;
    assign rsp.count           = res_reg.count;
    assign rsp.front_word_low  = front_entry.low;
    assign rsp.front_word_mid  = front_entry.mid;
    assign rsp.front_word_high = front_entry.high;
    assign rsp.back_word_low   = back_entry.low;
    assign rsp.back_word_mid   = back_entry.mid;
    assign rsp.back_word_high  = back_entry.high;

endmodule

`default_nettype wire

// File: rtl/deq_checker.sv
// Port-level assertions for the double-ended queue and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module deq_checker
    import deq_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    req_ready,
    input wire logic    rsp_valid,
    input wire logic    rsp_ready,
    input wire status_t status,
    input wire cnt_t    count,
    input wire word_t   front_word_low,
    input wire word_t   front_word_mid,
    input wire word_t   front_word_high,
    input wire word_t   back_word_low,
    input wire word_t   back_word_mid,
    input wire word_t   back_word_high
);

    // A refused push can only happen with a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL) |-> (count == CNT_W'(DEPTH)))
    else $error("full status with a queue that is not full");

    // A refused pop leaves an empty queue; its low front word and high back word are blank.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_EMPTY) |->
            (count == '0) && (front_word_low == '0) && (back_word_high == '0))
    else $error("empty status with a queue that is not empty");

    // With a single entry the front and the back are the same entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (count == CNT_W'(1)) |->
            (front_word_low == back_word_low) && (front_word_mid == back_word_mid) &&
            (front_word_high == back_word_high))
    else $error("front and back differ with one entry");

    // A stalled response blocks new requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request accepted while the response is stalled");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .status          (rsp.status),
    .count           (rsp.count),
    .front_word_low  (rsp.front_word_low),
    .front_word_mid  (rsp.front_word_mid),
    .front_word_high (rsp.front_word_high),
    .back_word_low   (rsp.back_word_low),
    .back_word_mid   (rsp.back_word_mid),
    .back_word_high  (rsp.back_word_high)
);

`default_nettype wire
